@@ sv/pfc_pkg.sv @@
// potential field classifier package: mode codes, controller states,
// controller/datapath command and status structs, fixed-point constants
`default_nettype none

package pfc_pkg;

    typedef enum logic [1:0] {
        MODE_CLEAR    = 2'd0,
        MODE_LOAD     = 2'd1,
        MODE_CLASSIFY = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_DIFF,
        ST_SQUARE,
        ST_ROOT_INIT,
        ST_ROOT,
        ST_DIV_INIT,
        ST_DIV,
        ST_ACC,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic start;
        logic rd;
        logic diff;
        logic square;
        logic root_init;
        logic root_step;
        logic div_init;
        logic div_step;
        logic accum;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic pt_last;
        logic step_last;
        logic out_busy;
    } t_sts;

    localparam int SCORE_W   = 24;
    localparam int TERM_W    = 17;
    localparam int FRAC_SH   = 16;
    localparam int DIV_STEPS = 25;
    localparam int ONE_Q8    = 256;
    localparam int STEP_W    = 5;

endpackage

`default_nettype wire

@@ sv/pfc_in_if.sv @@
// input channel of the potential field classifier: valid, ready and item fields
// no dependencies
`default_nettype none

interface pfc_in_if #(
    parameter int COORD_BITS = 10
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            mode;
    logic [COORD_BITS-1:0] x_coord;
    logic [COORD_BITS-1:0] y_coord;
    logic                  point_class;

    modport source(output valid, mode, x_coord, y_coord, point_class, input ready);
    modport sink(input valid, mode, x_coord, y_coord, point_class, output ready);
endinterface

`default_nettype wire

@@ sv/pfc_out_if.sv @@
// result channel of the potential field classifier: valid, ready and result fields
// no dependencies
`default_nettype none

interface pfc_out_if;
    logic               valid;
    logic               ready;
    logic               pixel_class;
    logic signed [23:0] score;

    modport source(output valid, pixel_class, score, input ready);
    modport sink(input valid, pixel_class, score, output ready);
endinterface

`default_nettype wire

@@ sv/potential_field_classifier.sv @@
// potential field classifier top level: joins controller and datapath to the
// input and result channels; uses pfc_pkg, pfc_in_if, pfc_out_if, pfc_ctrl, pfc_dp
//
// i_pix carries items: mode clear (empties the store), load (stores a labelled
// point, dropped once MAX_POINTS are held) or classify (pixel x, y). only
// classify produces a transaction on o_res: pixel_class and the signed Q7.16 score,
// class-0 potential sum minus class-1 sum, saturated to 24 bits
// clear and load are done from idle. classify walks the stored points one at
// a time through one distance, square-root and divider unit: per point the
// states read, diff, square, root init, COORD_BITS + 9 root steps, divide
// init, 25 divide steps and accumulate; after the last point (or at once
// with an empty store) an output state loads the result register
// one item is in work at a time; i_pix.ready is high only between items
// the result sits in an output register; while the receiver stalls the
// next items are accepted and a further classify waits at its end until the
// register frees
// reset empties the store and drops any pending result
`default_nettype none

module potential_field_classifier
    import pfc_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 10
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pfc_in_if.sink     i_pix,
    pfc_out_if.source  o_res
);

    t_cmd cmd;
    t_sts sts;
    logic ready;

    pfc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .i_mode  (i_pix.mode),
        .i_sts   (sts),
        .o_ready (ready),
        .o_cmd   (cmd)
    );

    pfc_dp #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_x           (i_pix.x_coord),
        .i_y           (i_pix.y_coord),
        .i_pc          (i_pix.point_class),
        .i_out_ready   (o_res.ready),
        .o_sts         (sts),
        .o_out_valid   (o_res.valid),
        .o_pixel_class (o_res.pixel_class),
        .o_score       (o_res.score)
    );

    assign i_pix.ready = ready;

    a_class_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.pixel_class == o_res.score[SCORE_W-1]))
        else $error("pixel class disagrees with score sign");

    a_classify_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready && (i_pix.mode == MODE_CLASSIFY)) |=> !i_pix.ready)
        else $error("classify did not hold off input");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");

endmodule

`default_nettype wire

@@ sv/pfc_ctrl.sv @@
// potential field classifier controller: sequences clear, load and per-point
// classify steps; uses pfc_pkg
`default_nettype none

module pfc_ctrl
    import pfc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [1:0] i_mode,
    input  wire t_sts       i_sts,
    output logic            o_ready,
    output t_cmd            o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    case (t_mode'(i_mode))
                        MODE_CLEAR: o_cmd.clear = 1'b1;
                        MODE_LOAD:  o_cmd.load  = 1'b1;
                        MODE_CLASSIFY: begin
                            o_cmd.start = 1'b1;
                            n_state = i_sts.count_zero ? ST_OUT : ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_DIFF;
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = ST_SQUARE;
            end
            ST_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = ST_ROOT_INIT;
            end
            ST_ROOT_INIT: begin
                o_cmd.root_init = 1'b1;
                n_state         = ST_ROOT;
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_sts.step_last) begin
                    n_state = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.step_last) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                o_cmd.accum = 1'b1;
                n_state     = i_sts.pt_last ? ST_OUT : ST_READ;
            end
            ST_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ sv/pfc_dp.sv @@
// potential field classifier datapath: point memory, distance, shift-subtract
// root and reciprocal divider, accumulator, output register; uses pfc_pkg
`default_nettype none

module pfc_dp
    import pfc_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 10
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    input  wire logic [COORD_BITS-1:0] i_x,
    input  wire logic [COORD_BITS-1:0] i_y,
    input  wire logic                  i_pc,
    input  wire logic                  i_out_ready,
    output t_sts                       o_sts,
    output logic                       o_out_valid,
    output logic                       o_pixel_class,
    output logic signed [SCORE_W-1:0]  o_score
);

    localparam int C     = COORD_BITS;
    localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int EW    = 2 * C + 1;
    localparam int RW    = C + 9;
    localparam int VW    = 2 * RW;
    localparam int DW    = RW + 1;
    localparam int AW0   = TERM_W + CW + 1;
    localparam int ACC_W = (AW0 > SCORE_W + 1) ? AW0 : SCORE_W + 1;

    logic [EW-1:0]           r_mem [MAX_POINTS];
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_idx;
    logic [C-1:0]            r_px;
    logic [C-1:0]            r_py;
    logic [EW-1:0]           r_rd;
    logic [C-1:0]            r_dx;
    logic [C-1:0]            r_dy;
    logic [2*C-1:0]          r_sqx;
    logic [2*C-1:0]          r_sqy;
    logic [VW-1:0]           r_v;
    logic [RW+1:0]           r_rem;
    logic [RW-1:0]           r_root;
    logic [DW-1:0]           r_den;
    logic [DW-1:0]           r_drem;
    logic [TERM_W-1:0]       r_q;
    logic [STEP_W-1:0]       r_step;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_ovalid;
    logic                    r_opc;
    logic [SCORE_W-1:0]      r_oscore;

    logic [C-1:0]            rd_x;
    logic [C-1:0]            rd_y;
    logic [RW+2:0]           rem_sh;
    logic [RW+2:0]           trial;
    logic                    rge;
    logic [DW:0]             dsh;
    logic                    dge;
    logic signed [ACC_W-1:0] term_ext;
    logic [ACC_W-SCORE_W:0]  acc_hi;
    logic [SCORE_W-1:0]      sat;
    logic                    full;

    assign rd_x     = r_rd[EW-1 -: C];
    assign rd_y     = r_rd[C:1];
    assign full     = (r_count == CW'(MAX_POINTS));
    assign rem_sh   = {r_rem[RW:0], r_v[VW-1 -: 2]};
    assign trial    = {1'b0, r_root, 2'b01};
    assign rge      = (rem_sh >= trial);
    assign dsh      = {r_drem, (r_step == STEP_W'(DIV_STEPS - 1))};
    assign dge      = (dsh >= {1'b0, r_den});
    assign term_ext = $signed({{(ACC_W - TERM_W){1'b0}}, r_q});
    assign acc_hi   = r_acc[ACC_W-1:SCORE_W-1];

    always_comb begin
        if ((&acc_hi) || !(|acc_hi)) begin
            sat = r_acc[SCORE_W-1:0];
        end else if (r_acc[ACC_W-1]) begin
            sat = {1'b1, {(SCORE_W - 1){1'b0}}};
        end else begin
            sat = {1'b0, {(SCORE_W - 1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !full) begin
            r_mem[r_count[AW-1:0]] <= {i_x, i_y, i_pc};
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.load && !full) begin
            r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_px  <= i_x;
            r_py  <= i_y;
            r_idx <= '0;
            r_acc <= '0;
        end
        if (i_cmd.diff) begin
            r_dx <= (r_px > rd_x) ? r_px - rd_x : rd_x - r_px;
            r_dy <= (r_py > rd_y) ? r_py - rd_y : rd_y - r_py;
        end
        if (i_cmd.square) begin
            r_sqx <= {{C{1'b0}}, r_dx} * {{C{1'b0}}, r_dx};
            r_sqy <= {{C{1'b0}}, r_dy} * {{C{1'b0}}, r_dy};
        end
        if (i_cmd.root_init) begin
            r_v    <= {1'b0, {1'b0, r_sqx} + {1'b0, r_sqy}, {FRAC_SH{1'b0}}};
            r_rem  <= '0;
            r_root <= '0;
            r_step <= STEP_W'(RW - 1);
        end
        if (i_cmd.root_step) begin
            r_rem  <= rge ? (RW + 2)'(rem_sh - trial) : rem_sh[RW+1:0];
            r_root <= {r_root[RW-2:0], rge};
            r_v    <= {r_v[VW-3:0], 2'b00};
            r_step <= r_step - STEP_W'(1);
        end
        if (i_cmd.div_init) begin
            r_den  <= DW'(ONE_Q8) + {1'b0, r_root};
            r_drem <= '0;
            r_q    <= '0;
            r_step <= STEP_W'(DIV_STEPS - 1);
        end
        if (i_cmd.div_step) begin
            r_drem <= dge ? DW'(dsh - {1'b0, r_den}) : dsh[DW-1:0];
            r_q    <= {r_q[TERM_W-2:0], dge};
            r_step <= r_step - STEP_W'(1);
        end
        if (i_cmd.accum) begin
            r_acc <= r_rd[0] ? r_acc - term_ext : r_acc + term_ext;
            r_idx <= r_idx + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_oscore <= sat;
            r_opc    <= sat[SCORE_W-1];
        end
    end

    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.pt_last    = ((r_idx + CW'(1)) == r_count);
    assign o_sts.step_last  = (r_step == '0);
    assign o_sts.out_busy   = r_ovalid && !i_out_ready;
    assign o_out_valid      = r_ovalid;
    assign o_pixel_class    = r_opc;
    assign o_score          = $signed(r_oscore);

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// testbench for potential_field_classifier: directed table, store overfill, then random
// clear/load/classify/unused-mode traffic, scored against an internal potential predictor
// depends on pfc_pkg, pfc_in_if, pfc_out_if and the block itself
`timescale 1ns / 1ps

module tb_top;
    import pfc_pkg::*;

    localparam int NPTS   = 64;
    localparam int CBITS  = 10;
    localparam int WDOG   = 200000;

    typedef struct packed {
        t_mode             mode;
        logic [CBITS-1:0]  x;
        logic [CBITS-1:0]  y;
        logic              cls;
    } t_item;

    typedef struct packed {
        logic               pixel_class;
        logic signed [23:0] score;
        logic               known;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    pfc_in_if #(.COORD_BITS(CBITS)) pix ();
    pfc_out_if res ();

    potential_field_classifier #(.MAX_POINTS(NPTS), .COORD_BITS(CBITS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix.sink),
        .o_res   (res.source)
    );

    logic [CBITS-1:0] pt_x [NPTS];
    logic [CBITS-1:0] pt_y [NPTS];
    logic             pt_c [NPTS];
    int               pt_n;

    t_verdict verdicts [$];
    t_item    table_items [$];
    t_verdict table_expect [$];
    int       errors;
    int       idle_cycles;
    bit       timed_out;
    bit       rx_stall_en;

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned potential(int ax, int ay, int bx, int by);
        longint unsigned dx, dy, r;
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        r = isqrt((dx * dx + dy * dy) << 16);
        return (64'd1 << 24) / (64'd256 + r);
    endfunction

    // updates store, returns whether a result is due
    function automatic bit classify_item(t_item it, output t_verdict v);
        longint signed s0, s1, s;
        s0 = 0;
        s1 = 0;
        v = '0;
        case (it.mode)
            MODE_CLEAR: pt_n = 0;
            MODE_LOAD: begin
                if (pt_n < NPTS) begin
                    pt_x[pt_n] = it.x;
                    pt_y[pt_n] = it.y;
                    pt_c[pt_n] = it.cls;
                    pt_n++;
                end
            end
            MODE_CLASSIFY: begin
                for (int k = 0; k < pt_n; k++) begin
                    if (pt_c[k]) s1 += potential(it.x, it.y, pt_x[k], pt_y[k]);
                    else         s0 += potential(it.x, it.y, pt_x[k], pt_y[k]);
                end
                s = s0 - s1;
                if (s > 8388607) s = 8388607;
                if (s < -8388608) s = -8388608;
                v.pixel_class = (s < 0);
                v.score = s[23:0];
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    task automatic send_item(t_item it, t_verdict fixed);
        t_verdict v;
        pix.valid <= 1'b1;
        pix.mode <= it.mode;
        pix.x_coord <= it.x;
        pix.y_coord <= it.y;
        pix.point_class <= it.cls;
        do @(posedge i_clk); while (!(pix.valid && pix.ready) && !timed_out);
        if (classify_item(it, v)) begin
            if (fixed.known && (fixed.score != v.score || fixed.pixel_class != v.pixel_class)) begin
                $error("table row disagrees with predictor: score %0d vs %0d",
                    fixed.score, v.score);
                errors++;
            end
            verdicts.push_back(v);
        end
    endtask

    task automatic drop_valid(int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            pix.valid <= 1'b0;
            pix.mode <= t_mode'($urandom_range(0, 3));
            pix.x_coord <= CBITS'($urandom);
            pix.y_coord <= CBITS'($urandom);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (verdicts.size() != 0 && !timed_out) @(negedge i_clk);
        repeat (4 * NPTS * (CBITS + 40) / 10 + 20) @(negedge i_clk);
    endtask

    function automatic t_item mk(t_mode m, int x, int y, int c);
        t_item it;
        it.mode = m;
        it.x = CBITS'(x);
        it.y = CBITS'(y);
        it.cls = c[0];
        return it;
    endfunction

    task automatic add_row(t_item it, bit known, int sc);
        t_verdict v;
        v.known = known;
        v.score = 24'(sc);
        v.pixel_class = (sc < 0);
        table_items.push_back(it);
        table_expect.push_back(v);
    endtask

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (!rx_stall_en) res.ready <= 1'b1;
        else res.ready <= ($urandom_range(0, 7) < 5);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) begin
            if (verdicts.size() == 0) begin
                $error("unexpected transaction: score %0d", res.score);
                errors++;
            end else begin
                t_verdict e;
                e = verdicts.pop_front();
                if (res.pixel_class !== e.pixel_class) begin
                    $error("pixel_class expected %0b actual %0b", e.pixel_class,
                        res.pixel_class);
                    errors++;
                end
                if (res.score !== e.score) begin
                    $error("score expected %0d actual %0d", e.score, res.score);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pix.valid && pix.ready) || (res.valid && res.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG && !timed_out) begin
            timed_out = 1'b1;
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        t_item it;
        int sent, burst;
        errors = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        rx_stall_en = 1'b0;
        pt_n = 0;
        pix.valid = 1'b0;
        pix.mode = MODE_CLEAR;
        pix.x_coord = '0;
        pix.y_coord = '0;
        pix.point_class = 1'b0;
        res.ready = 1'b1;

        add_row(mk(MODE_CLASSIFY, 0, 0, 0), 1, 0);
        add_row(mk(MODE_LOAD, 0, 0, 0), 0, 0);
        add_row(mk(MODE_CLASSIFY, 0, 0, 0), 1, 65536);
        add_row(mk(MODE_LOAD, 1023, 1023, 1), 0, 0);
        add_row(mk(MODE_CLASSIFY, 1023, 1023, 1), 0, 0);
        add_row(mk(MODE_CLASSIFY, 0, 1023, 0), 0, 0);
        add_row(mk(t_mode'(2'd3), 1023, 0, 1), 0, 0);
        add_row(mk(MODE_CLEAR, 5, 5, 1), 0, 0);
        add_row(mk(MODE_CLASSIFY, 512, 512, 0), 1, 0);
        add_row(mk(MODE_LOAD, 300, 700, 1), 0, 0);
        add_row(mk(MODE_CLASSIFY, 300, 700, 0), 1, -65536);
        add_row(mk(MODE_LOAD, 300, 700, 0), 0, 0);
        add_row(mk(MODE_CLASSIFY, 300, 700, 1), 1, 0);
        add_row(mk(MODE_CLASSIFY, 1023, 0, 0), 0, 0);
        add_row(mk(MODE_CLEAR, 0, 0, 0), 0, 0);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (table_items[i]) begin
            send_item(table_items[i], table_expect[i]);
            drop_valid($urandom_range(0, 2));
        end

        // fill the store past capacity so drops are exercised
        for (int k = 0; k < NPTS + 3; k++) begin
            send_item(mk(MODE_LOAD, $urandom, $urandom, $urandom), '0);
            drop_valid(0);
        end
        send_item(mk(MODE_CLASSIFY, $urandom, $urandom, 0), '0);
        drop_valid(1);
        wait_drained();
        rx_stall_en = 1'b1;

        sent = 0;
        while (sent < 500 && !timed_out) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++) begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 4) it = mk(MODE_CLEAR, $urandom, $urandom, $urandom);
                else if (r < 6) it = mk(t_mode'(2'd3), $urandom, $urandom, $urandom);
                else if (r < 60 && pt_n < 12)
                    it = mk(MODE_LOAD, $urandom, $urandom, $urandom);
                else if (r < 40) it = mk(MODE_LOAD, $urandom, $urandom, $urandom);
                else it = mk(MODE_CLASSIFY, $urandom, $urandom, $urandom);
                send_item(it, '0);
                sent++;
                if (b != burst - 1) drop_valid(0);
            end
            if (sent % 97 < 12) begin
                @(negedge i_clk);
                pix.valid <= 1'b0;
                wait_drained();
            end else begin
                drop_valid($urandom_range(0, 1) ? $urandom_range(1, 30) : 0);
            end
        end
        @(negedge i_clk);
        pix.valid <= 1'b0;
        wait_drained();

        if (errors == 0 && verdicts.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
